// ----- rtl/core/lagac_pkg.sv -----
// ----------------------------------------------------------------------------
// lagac_pkg: shared types and constants of the lag-one autocorrelation block
// Widths of the burst record, queue depth and the arctangent table.
// ----------------------------------------------------------------------------
package lagac_pkg;

  localparam int MaxShots    = 16;
  localparam int ShotW       = 7;
  localparam int AccW        = 40;
  localparam int CordicSteps = 28;
  localparam int QueueDepth  = 2;

  // one finished burst, handed from the front to the back
  typedef struct packed {
    logic signed [AccW-1:0] acc_re;
    logic signed [AccW-1:0] acc_im;
    logic [AccW-1:0]        energy_head;
    logic [AccW-1:0]        energy_tail;
  } burst_t;

  // arctangent of 2^-idx, pi = 2^31
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/lagac_if.sv -----
// ----------------------------------------------------------------------------
// lagac_if: sample and result channels
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lagac_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_i;
  logic signed [15:0] sample_q;
  logic               last_shot;
  modport source (output valid, sample_i, sample_q, last_shot, input ready);
  modport sink (input valid, sample_i, sample_q, last_shot, output ready);
endinterface

interface lagac_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] phase_shift;
  logic [15:0]        corr_coeff;
  logic               passed_gate;
  modport source (output valid, phase_shift, corr_coeff, passed_gate, input ready);
  modport sink (input valid, phase_shift, corr_coeff, passed_gate, output ready);
endinterface

// ----- rtl/core/lagac_front.sv -----
// ----------------------------------------------------------------------------
// lagac_front: per-sample accumulation
// Takes one sample a cycle while the queue is not full, sums lag-one products and energies, and pushes
// the burst record into the queue on the last sample.
// ----------------------------------------------------------------------------
module lagac_front (
  input  logic              clk,
  input  logic              rst,
  lagac_in_if.sink          in_ch,
  input  logic              full,
  output logic              push,
  output lagac_pkg::burst_t rec
);

  logic signed [15:0] prev_i;
  logic signed [15:0] prev_q;
  logic signed [lagac_pkg::AccW-1:0] lag_acc_re;
  logic signed [lagac_pkg::AccW-1:0] lag_acc_im;
  logic [lagac_pkg::AccW-1:0] energy_head;
  logic [lagac_pkg::AccW-1:0] energy_tail;
  logic [lagac_pkg::ShotW-1:0] shot_count;

  logic accept, take, has_prev;
  logic signed [31:0] p_ii, p_qq, p_qi, p_iq, e_pi, e_pq, e_ci, e_cq;
  logic signed [32:0] d_re, d_im;
  logic signed [lagac_pkg::AccW-1:0] re_next, im_next;
  logic [lagac_pkg::AccW-1:0] eh_next, et_next;

  assign in_ch.ready = !full;
  assign accept = in_ch.valid && in_ch.ready;
  assign take = shot_count < lagac_pkg::ShotW'(lagac_pkg::MaxShots);
  assign has_prev = shot_count != '0;

  // lag-one products and energies of this pair
  always_comb begin
    p_ii = prev_i * in_ch.sample_i;
    p_qq = prev_q * in_ch.sample_q;
    p_qi = prev_q * in_ch.sample_i;
    p_iq = prev_i * in_ch.sample_q;
    e_pi = prev_i * prev_i;
    e_pq = prev_q * prev_q;
    e_ci = in_ch.sample_i * in_ch.sample_i;
    e_cq = in_ch.sample_q * in_ch.sample_q;
    d_re = 33'(p_ii) + 33'(p_qq);
    d_im = 33'(p_qi) - 33'(p_iq);
    re_next = lag_acc_re;
    im_next = lag_acc_im;
    eh_next = energy_head;
    et_next = energy_tail;
    if (take && has_prev) begin
      re_next = lag_acc_re + lagac_pkg::AccW'(d_re);
      im_next = lag_acc_im + lagac_pkg::AccW'(d_im);
      eh_next = energy_head + lagac_pkg::AccW'($unsigned(e_pi))
                + lagac_pkg::AccW'($unsigned(e_pq));
      et_next = energy_tail + lagac_pkg::AccW'($unsigned(e_ci))
                + lagac_pkg::AccW'($unsigned(e_cq));
    end
  end

  // hand the finished burst to the queue
  assign push = accept && in_ch.last_shot;
  assign rec.acc_re = re_next;
  assign rec.acc_im = im_next;
  assign rec.energy_head = eh_next;
  assign rec.energy_tail = et_next;

  // advance or clear the burst state
  always_ff @(posedge clk) begin
    if (rst || push) begin
      prev_i      <= '0;
      prev_q      <= '0;
      lag_acc_re  <= '0;
      lag_acc_im  <= '0;
      energy_head <= '0;
      energy_tail <= '0;
      shot_count  <= '0;
    end else if (accept && take) begin
      prev_i      <= in_ch.sample_i;
      prev_q      <= in_ch.sample_q;
      lag_acc_re  <= re_next;
      lag_acc_im  <= im_next;
      energy_head <= eh_next;
      energy_tail <= et_next;
      shot_count  <= shot_count + 1'b1;
    end
  end

endmodule

// ----- rtl/core/lagac_queue.sv -----
// ----------------------------------------------------------------------------
// lagac_queue: short queue of burst records
// Lets the sample front and the arithmetic back stall independently.
// ----------------------------------------------------------------------------
module lagac_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lagac_pkg::burst_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              rvalid,
  output lagac_pkg::burst_t rdata
);

  localparam int PtrW = $clog2(lagac_pkg::QueueDepth);

  lagac_pkg::burst_t mem [lagac_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign full   = count == (PtrW+1)'(lagac_pkg::QueueDepth);
  assign rvalid = count != '0;
  assign rdata  = mem[rd_ptr];

  // store records
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(lagac_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(lagac_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

// ----- rtl/core/lagac_back.sv -----
// ----------------------------------------------------------------------------
// lagac_back: coefficient and phase sequencer
// Squares and energy product by 20x20 partial products, bit-serial root
// search for the coefficient, normalize, CORDIC vectoring, output register.
// ----------------------------------------------------------------------------
module lagac_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              rec_valid,
  input  lagac_pkg::burst_t rec,
  output logic              pop,
  input  logic [15:0]       min_correlation,
  lagac_out_if.source       out_ch
);

  localparam int WideW = 112;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_TRY, ST_CMP, ST_GATE, ST_NORM, ST_ROT, ST_FIN, ST_HOLD
  } state_t;

  state_t state;
  logic signed [39:0] acc_re, acc_im;
  logic [39:0] ar, ai, eh, et;
  logic [3:0]  mk;
  logic [3:0]  tag;
  logic        pv;
  logic [39:0] prod;
  logic [80:0] r_acc;
  logic [79:0] p_acc;
  logic [WideW-1:0] s_sum, t_sum, trial;
  logic [15:0] coeff;
  logic [3:0]  bk;
  logic        gate;
  logic [41:0] ux, uy;
  logic signed [41:0] x, y;
  logic signed [32:0] z;
  logic [4:0]  ri;
  logic signed [15:0] phase;
  logic        load_out;

  logic [19:0] op_a, op_b;
  logic [39:0] src_a, src_b;
  logic [80:0] pp_shift;
  logic [WideW-1:0] r_wide;
  logic signed [41:0] dx, dy;
  logic signed [32:0] atan_v, zc, zq, zr;

  // operand chunks for the partial product issued this cycle
  always_comb begin
    case (mk[3:2])
      2'd0: begin src_a = ar; src_b = ar; end
      2'd1: begin src_a = ai; src_b = ai; end
      default: begin src_a = eh; src_b = et; end
    endcase
    op_a = mk[1] ? src_a[39:20] : src_a[19:0];
    op_b = mk[0] ? src_b[39:20] : src_b[19:0];
    case (2'(tag[1]) + 2'(tag[0]))
      2'd0: pp_shift = 81'(prod);
      2'd1: pp_shift = 81'(prod) << 20;
      default: pp_shift = 81'(prod) << 40;
    endcase
  end

  assign r_wide = WideW'(r_acc) << 30;

  // CORDIC step terms and final angle mapping
  always_comb begin
    dx = y >>> ri;
    dy = x >>> ri;
    atan_v = 33'(lagac_pkg::atan_entry(ri));
    zc = z;
    if (zc < 0) zc = '0;
    if (zc > 33'sh40000000) zc = 33'sh40000000;
    zq = acc_re[39] ? 33'sh80000000 - zc : zc;
    if (acc_im[39]) zq = -zq;
    zr = (zq + 33'sd32768) >>> 16;
  end

  assign pop = (state == ST_IDLE) && rec_valid;

  // load the output register once the previous result has left
  assign load_out = (state == ST_HOLD) && (!out_ch.valid || out_ch.ready);

  // sequence one burst and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_ch.valid <= 1'b0;
      pv           <= 1'b0;
    end else begin
      if (load_out) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (rec_valid) begin
            acc_re <= rec.acc_re;
            acc_im <= rec.acc_im;
            ar     <= rec.acc_re[39] ? 40'(-rec.acc_re) : 40'(rec.acc_re);
            ai     <= rec.acc_im[39] ? 40'(-rec.acc_im) : 40'(rec.acc_im);
            eh     <= rec.energy_head;
            et     <= rec.energy_tail;
            r_acc  <= '0;
            p_acc  <= '0;
            mk     <= '0;
            pv     <= 1'b0;
            coeff  <= '0;
            gate   <= 1'b0;
            phase  <= '0;
            if (rec.energy_head == '0 || rec.energy_tail == '0) begin
              state <= ST_HOLD;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (mk != 4'd12) begin
            prod <= op_a * op_b;
            tag  <= mk;
            mk   <= mk + 1'b1;
          end
          pv <= mk != 4'd12;
          if (pv) begin
            if (tag[3]) begin
              p_acc <= p_acc + 80'(pp_shift);
            end else begin
              r_acc <= r_acc + pp_shift;
            end
          end
          if (mk == 4'd12 && !pv) begin
            s_sum <= '0;
            t_sum <= '0;
            bk    <= 4'd15;
            state <= ST_TRY;
          end
        end
        ST_TRY: begin
          trial <= s_sum + (t_sum << (5'(bk) + 5'd1)) + (WideW'(p_acc) << (5'(bk) << 1));
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (trial <= r_wide) begin
            s_sum     <= trial;
            t_sum     <= t_sum + (WideW'(p_acc) << bk);
            coeff[bk] <= 1'b1;
          end
          if (bk == '0) begin
            state <= ST_GATE;
          end else begin
            bk    <= bk - 1'b1;
            state <= ST_TRY;
          end
        end
        ST_GATE: begin
          gate <= coeff > min_correlation;
          ux   <= 42'(ar);
          uy   <= 42'(ai);
          if (coeff > min_correlation && (ar != '0 || ai != '0)) begin
            state <= ST_NORM;
          end else begin
            state <= ST_HOLD;
          end
        end
        ST_NORM: begin
          if ((ux | uy) < (42'd1 << 37)) begin
            ux <= ux << 1;
            uy <= uy << 1;
          end else begin
            x     <= $signed(ux);
            y     <= $signed(uy);
            z     <= '0;
            ri    <= '0;
            state <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (!y[41]) begin
            x <= x + dx;
            y <= y - dy;
            z <= z + atan_v;
          end else begin
            x <= x - dx;
            y <= y + dy;
            z <= z - atan_v;
          end
          if (ri == 5'(lagac_pkg::CordicSteps - 1)) begin
            state <= ST_FIN;
          end else begin
            ri <= ri + 1'b1;
          end
        end
        ST_FIN: begin
          phase <= zr[15:0];
          state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (load_out) begin
            out_ch.phase_shift <= phase;
            out_ch.corr_coeff  <= coeff;
            out_ch.passed_gate <= gate;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/lag_one_autocorrelation_phase.sv -----
// ----------------------------------------------------------------------------
// lag_one_autocorrelation_phase: lag-one correlation and phase per burst
// Top level: configuration register, sample front, queue, arithmetic back.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one complex sample per request; last_shot closes a burst.
//   out_ch carries one result (phase, coefficient, gate flag) per burst.
//   Samples are taken one per cycle while the queue has room; after the
//   sixteenth sample of a burst further samples are dropped until last_shot.
//   A closed burst waits in a two-entry queue; the front stalls only when
//   both entries hold bursts not yet started by the back.
//   The back works through partial products, the root search, normalizing
//   and 28 CORDIC steps; a burst with zero energy skips straight to its
//   result, and one with the gate closed skips normalizing and CORDIC.
//   A result stays in its output register until taken; the back starts the
//   next burst meanwhile and holds at its end while out_ch is stalled.
//   Synchronous reset clears burst state, queue, output valid and the
//   threshold register min_correlation (APB address 0).
// ----------------------------------------------------------------------------
module lag_one_autocorrelation_phase (
  input  logic        clk,
  input  logic        rst,
  lagac_in_if.sink    in_ch,
  lagac_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] min_correlation;
  logic push, full, pop, rec_valid;
  lagac_pkg::burst_t wrec, rrec;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? 32'(min_correlation) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_correlation <= '0;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      min_correlation <= pwdata[15:0];
    end
  end

  lagac_front u_front (
    .clk  (clk),
    .rst  (rst),
    .in_ch(in_ch),
    .full (full),
    .push (push),
    .rec  (wrec)
  );

  lagac_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wrec),
    .full  (full),
    .pop   (pop),
    .rvalid(rec_valid),
    .rdata (rrec)
  );

  lagac_back u_back (
    .clk            (clk),
    .rst            (rst),
    .rec_valid      (rec_valid),
    .rec            (rrec),
    .pop            (pop),
    .min_correlation(min_correlation),
    .out_ch         (out_ch)
  );

endmodule

// ----- verif/lag_one_autocorrelation_phase_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lag_one_autocorrelation_phase_test: burst correlation and phase testbench
// Streams bursts of complex samples with directed corner cases and random
// bursts, predicts the coefficient, gate and phase of every burst, and
// checks each result in order under varying idle and stall patterns.
// ----------------------------------------------------------------------------
module lag_one_autocorrelation_phase_test;

  localparam int  RegMinCorr  = 0;
  localparam int  DrainCycles = 300;
  localparam int  StallLimit  = 20000;

  typedef struct packed {
    logic signed [15:0] phase_shift;
    logic [15:0]        corr_coeff;
    logic               passed_gate;
  } burst_result_t;

  // arctangent of 2^-k, pi = 2^31
  localparam longint ATAN_STEP [28] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lagac_in_if  in_ch ();
  lagac_out_if out_ch ();

  lag_one_autocorrelation_phase uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [15:0]   min_corr;
  longint        prev_i, prev_q, lag_re, lag_im, energy_head, energy_tail;
  int            shots;
  burst_result_t expected_results[$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample_i = '0;
    in_ch.sample_q = '0;
    in_ch.last_shot = 1'b0;
    out_ch.ready = 1'b0;
  end

  // floor(32768 * |acc| / sqrt(eh * et)) by search on squares
  function automatic logic [15:0] corr_of(longint re, longint im, longint eh, longint et);
    logic [127:0] ar, ai, rhs, prod, m;
    longint       lo, hi, mid;
    ar = (re < 0) ? -re : re;
    ai = (im < 0) ? -im : im;
    rhs = (ar * ar + ai * ai) << 30;
    prod = 128'(eh) * 128'(et);
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      m = 128'(mid);
      if (prod * m * m <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[15:0];
  endfunction

  // vectoring CORDIC on the first-quadrant image, then restore quadrant
  function automatic logic [15:0] phase_of(longint re, longint im);
    logic [63:0] ux, uy;
    longint      x, y, z, dx, dy, r;
    ux = (re < 0) ? -re : re;
    uy = (im < 0) ? -im : im;
    if (ux == 0 && uy == 0) return '0;
    while ((ux | uy) < (64'd1 << 37)) begin
      ux = ux << 1;
      uy = uy << 1;
    end
    x = ux;
    y = uy;
    z = 0;
    for (int k = 0; k < 28; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_STEP[k];
      end else begin
        x -= dx; y += dy; z -= ATAN_STEP[k];
      end
    end
    if (z < 0) z = 0;
    if (z > (64'sd1 <<< 30)) z = 64'sd1 <<< 30;
    if (re < 0) z = (64'sd1 <<< 31) - z;
    if (im < 0) z = -z;
    r = (z + 32768) >>> 16;
    return r[15:0];
  endfunction

  function automatic void clear_burst();
    prev_i = 0; prev_q = 0; lag_re = 0; lag_im = 0;
    energy_head = 0; energy_tail = 0; shots = 0;
  endfunction

  // advance the predictor by one accepted sample
  function automatic void predict_sample(logic signed [15:0] si, logic signed [15:0] sq,
                                         logic last);
    longint        ci, cq;
    burst_result_t res;
    ci = si;
    cq = sq;
    if (shots < lagac_pkg::MaxShots) begin
      if (shots > 0) begin
        lag_re += prev_i * ci + prev_q * cq;
        lag_im += prev_q * ci - prev_i * cq;
        energy_head += prev_i * prev_i + prev_q * prev_q;
        energy_tail += ci * ci + cq * cq;
      end
      prev_i = ci;
      prev_q = cq;
      shots++;
    end
    if (!last) return;
    res = '0;
    if (energy_head != 0 && energy_tail != 0) begin
      res.corr_coeff = corr_of(lag_re, lag_im, energy_head, energy_tail);
      if (res.corr_coeff > min_corr) begin
        res.passed_gate = 1'b1;
        res.phase_shift = phase_of(lag_re, lag_im);
      end
    end
    expected_results.push_back(res);
    clear_burst();
  endfunction

  // send one sample request; starts and ends at a falling edge
  task automatic send_sample(logic signed [15:0] si, logic signed [15:0] sq, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_i <= si;
    in_ch.sample_q <= sq;
    in_ch.last_shot <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_sample(si, sq, last);
    @(negedge clk);
  endtask

  // hold the sender until every result is back, then let the back settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_threshold(logic [15:0] value);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 3'(RegMinCorr * 4); pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    min_corr = value;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // one burst of n samples; kind selects noise, phasor or extremes
  task automatic send_burst(int n, int kind);
    real         amp, step, ph0;
    int          vi, vq, nz;
    amp = $urandom_range(32767);
    step = ($urandom_range(65535) / 65536.0 - 0.5) * 6.2832;
    ph0 = $urandom_range(65535) / 65536.0 * 6.2832;
    nz = $urandom_range(4096);
    for (int k = 0; k < n; k++) begin
      case (kind)
        0: begin
          vi = $signed(16'($urandom));
          vq = $signed(16'($urandom));
        end
        1: begin
          vi = $rtoi(amp * $cos(ph0 + k * step)) + $urandom_range(2 * nz) - nz;
          vq = $rtoi(amp * $sin(ph0 + k * step)) + $urandom_range(2 * nz) - nz;
          vi = (vi > 32767) ? 32767 : ((vi < -32768) ? -32768 : vi);
          vq = (vq > 32767) ? 32767 : ((vq < -32768) ? -32768 : vq);
        end
        default: begin
          vi = $urandom_range(1) ? 32767 : -32768;
          vq = $urandom_range(1) ? 32767 : -32768;
        end
      endcase
      send_sample(16'(vi), 16'(vq), k == n - 1);
    end
  endtask

  task automatic test_directed();
    write_threshold(16'd0);
    send_sample(16'sd1234, -16'sd77, 1'b1);           // lone sample
    for (int k = 0; k < 4; k++) send_sample('0, '0, k == 3);  // no energy
    send_sample('0, '0, 1'b0);                        // empty head energy
    send_sample(16'sd5, 16'sd5, 1'b1);
    send_sample(16'sd1, '0, 1'b0);                    // phase of pi
    send_sample(-16'sd1, '0, 1'b1);
    send_sample(16'sd1, '0, 1'b0);                    // cancelling accumulator
    send_sample('0, 16'sd1, 1'b0);
    send_sample(16'sd1, '0, 1'b1);
    for (int k = 0; k < lagac_pkg::MaxShots; k++)     // full-scale burst
      send_sample(-16'sd32768, -16'sd32768, k == lagac_pkg::MaxShots - 1);
    send_sample(16'sd32767, '0, 1'b0);                // negative imaginary
    send_sample(16'sd30000, 16'sd12000, 1'b1);
    send_burst(lagac_pkg::MaxShots + 4, 1);           // overlong burst
    write_threshold(16'd32768);                       // gate always closed
    send_burst(8, 1);
    write_threshold(16'hFFFF);
    send_burst(8, 2);
  endtask

  task automatic test_random(int n_items);
    int sent, n, sel;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(99);
      if (sel < 5) n = 1;
      else if (sel < 15) n = $urandom_range(lagac_pkg::MaxShots + 8, lagac_pkg::MaxShots + 1);
      else n = $urandom_range(lagac_pkg::MaxShots, 2);
      sel = $urandom_range(99);
      send_burst(n, (sel < 60) ? 1 : ((sel < 90) ? 0 : 2));
      sent += n;
    end
  endtask

  task automatic test_idle_phases();
    int src_pct[4] = '{0, 78, 0, 11};
    int snk_pct[4] = '{0, 0, 78, 11};
    for (int p = 0; p < 4; p++) begin
      src_idle_pct = src_pct[p];
      snk_stall_pct = snk_pct[p];
      write_threshold(16'($urandom_range(32768)));
      test_random(120);
      write_threshold((p % 2) ? 16'd32768 : 16'd0);
      test_random(120);
    end
  endtask

  // receiver: random stall
  always @(negedge clk) out_ch.ready <= !rst && ($urandom_range(99) >= snk_stall_pct);

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    burst_result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: phase %0d coeff %0d gate %0b",
                                   out_ch.phase_shift, out_ch.corr_coeff, out_ch.passed_gate);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.phase_shift !== exp_r.phase_shift || out_ch.corr_coeff !== exp_r.corr_coeff
            || out_ch.passed_gate !== exp_r.passed_gate) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: phase %0d/%0d coeff %0d/%0d gate %0b/%0b (exp/act)",
                     exp_r.phase_shift, out_ch.phase_shift, exp_r.corr_coeff,
                     out_ch.corr_coeff, exp_r.passed_gate, out_ch.passed_gate);
        end
      end
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    min_corr = '0;
    clear_burst();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_idle_phases();
    drain();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
